// ===== design/nps_pkg.sv =====
// Package for the note phrase segmenter: constants, configuration register
// indexes and the command and status structs between controller and datapath.
// No dependencies.
package nps_pkg;

  localparam int unsigned TicksPerBar = 1920;
  localparam logic [15:0] GapThrReset = 16'(TicksPerBar / 2);
  localparam logic [15:0] MinLenReset = 16'(TicksPerBar);

  localparam int unsigned QuoW  = 16;
  localparam int unsigned CntW  = $clog2(QuoW + 1);
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAP_THR = 1'b0,
    CFG_MIN_LEN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic accept;     // take the input item into the input registers
    logic apply;      // fold the held item into the phrase state
    logic div_start;  // start the density division on the open phrase
    logic load_out;   // move the finished phrase into the output register
    logic out_last;   // last_in_run for the phrase being loaded
    logic clear;      // close the phrase after the final note
  } cmd_t;

  typedef struct packed {
    logic split;      // the held note starts a new phrase
    logic cur_ok;     // the open phrase is long enough to report
    logic new_ok;     // a phrase of the held note alone is long enough
    logic fin;        // the held note is the final one
    logic div_done;   // the division has finished
    logic out_free;   // the output register can take a phrase this cycle
  } sts_t;

endpackage

// ===== design/nps_ctrl.sv =====
// Controller state machine of the note phrase segmenter.
// Sequences each note through evaluation, division and output. Uses nps_pkg.
module nps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  nps_pkg::sts_t sts_i,
  output nps_pkg::cmd_t cmd_o
);
  import nps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_FINAL = 4'b0100,
    S_DIV   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   pend_fin_q, pend_fin_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pend_fin_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_fin_q <= pend_fin_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pend_fin_d = pend_fin_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.split && sts_i.cur_ok) begin
          cmd_o.div_start = 1'b1;
          pend_fin_d      = 1'b0;
          state_d         = S_DIV;
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = S_FINAL;
        end
      end
      S_FINAL: begin
        if (sts_i.fin && sts_i.cur_ok) begin
          cmd_o.div_start = 1'b1;
          pend_fin_d      = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.clear = sts_i.fin;
          state_d     = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts_i.div_done && sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_last = pend_fin_q || !(sts_i.fin && sts_i.new_ok);
          if (pend_fin_q) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cmd_o.apply = 1'b1;
            state_d     = S_FINAL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/nps_dpath.sv =====
// Datapath of the note phrase segmenter: configuration registers, phrase
// state, a bit-serial density divider and the output register. Uses nps_pkg.
module nps_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nps_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [nps_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [31:0]                      start_tick_i,
  input  logic [23:0]                      note_length_i,
  input  logic [6:0]                       pitch_i,
  input  logic                             is_final_i,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [31:0]                      seg_start_o,
  output logic [31:0]                      seg_end_o,
  output logic [15:0]                      density_q8_8_o,
  output logic [6:0]                       pitch_lo_o,
  output logic [6:0]                       pitch_hi_o,
  output logic                             last_in_run_o,
  input  nps_pkg::cmd_t                    cmd_i,
  output nps_pkg::sts_t                    sts_o
);
  import nps_pkg::*;

  logic [15:0] gap_thr_q, min_len_q;

  logic        open_q;
  logic [31:0] open_start_q, open_end_q, sum_q;
  logic [6:0]  open_low_q, open_high_q;

  logic [31:0] st_q, en_q;
  logic [23:0] nl_q;
  logic [6:0]  pitch_q;
  logic        fin_q;

  logic [CntW-1:0] cnt_q;
  logic [31:0]     dsor_q, rem_q;
  logic [15:0]     low_q, quo_q;
  logic            sat_q, zlen_q;

  logic        out_valid_q;
  logic [31:0] o_start_q, o_end_q;
  logic [15:0] o_dens_q;
  logic [6:0]  o_low_q, o_high_q;
  logic        o_last_q;

  logic [32:0] en_sum;
  logic [31:0] en_sat;
  logic [32:0] dur_sum;
  logic [31:0] dur_sat;
  logic [31:0] gap, cur_len, new_len;
  logic        split;
  logic [32:0] trial;
  logic        trial_ge;
  logic [15:0] dens;

  assign en_sum  = {1'b0, start_tick_i} + {9'b0, note_length_i};
  assign en_sat  = en_sum[32] ? '1 : en_sum[31:0];
  assign dur_sum = {1'b0, sum_q} + {9'b0, nl_q};
  assign dur_sat = dur_sum[32] ? '1 : dur_sum[31:0];

  assign gap     = (st_q > open_end_q) ? (st_q - open_end_q) : '0;
  assign split   = open_q && (gap >= {16'b0, gap_thr_q});
  assign cur_len = open_end_q - open_start_q;
  assign new_len = en_q - st_q;

  assign trial    = {rem_q, low_q[15]};
  assign trial_ge = trial >= {1'b0, dsor_q};
  assign dens     = sat_q ? 16'hFFFF : (zlen_q ? 16'h0000 : quo_q);

  assign sts_o.split    = split;
  assign sts_o.cur_ok   = cur_len >= {16'b0, min_len_q};
  assign sts_o.new_ok   = new_len >= {16'b0, min_len_q};
  assign sts_o.fin      = fin_q;
  assign sts_o.div_done = (cnt_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_thr_q    <= GapThrReset;
      min_len_q    <= MinLenReset;
      open_q       <= 1'b0;
      open_start_q <= '0;
      open_end_q   <= '0;
      open_low_q   <= '0;
      open_high_q  <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_GAP_THR: gap_thr_q <= cfg_data_i;
          CFG_MIN_LEN: min_len_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.apply) begin
        open_q <= 1'b1;
        if (!open_q || split) begin
          open_start_q <= st_q;
          open_end_q   <= en_q;
          open_low_q   <= pitch_q;
          open_high_q  <= pitch_q;
          sum_q        <= {8'b0, nl_q};
        end else begin
          if (en_q > open_end_q) open_end_q <= en_q;
          if (pitch_q < open_low_q) open_low_q <= pitch_q;
          if (pitch_q > open_high_q) open_high_q <= pitch_q;
          sum_q <= dur_sat;
        end
      end else if (cmd_i.clear) begin
        open_q       <= 1'b0;
        open_start_q <= '0;
        open_end_q   <= '0;
        open_low_q   <= '0;
        open_high_q  <= '0;
        sum_q        <= '0;
      end
      if (cmd_i.div_start) begin
        cnt_q <= CntW'(QuoW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      st_q    <= start_tick_i;
      en_q    <= en_sat;
      nl_q    <= note_length_i;
      pitch_q <= pitch_i;
      fin_q   <= is_final_i;
    end
    if (cmd_i.div_start) begin
      dsor_q <= cur_len;
      rem_q  <= {8'b0, sum_q[31:8]};
      low_q  <= {sum_q[7:0], 8'h00};
      quo_q  <= '0;
      zlen_q <= (cur_len == '0);
      sat_q  <= (cur_len == '0) ? (sum_q != '0) : ({8'b0, sum_q} >= {cur_len, 8'h00});
    end else if (cnt_q != '0) begin
      rem_q <= trial_ge ? 32'(trial - {1'b0, dsor_q}) : trial[31:0];
      low_q <= {low_q[14:0], 1'b0};
      quo_q <= {quo_q[14:0], trial_ge};
    end
    if (cmd_i.load_out) begin
      o_start_q <= open_start_q;
      o_end_q   <= open_end_q;
      o_dens_q  <= dens;
      o_low_q   <= open_low_q;
      o_high_q  <= open_high_q;
      o_last_q  <= cmd_i.out_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign seg_start_o    = o_start_q;
  assign seg_end_o      = o_end_q;
  assign density_q8_8_o = o_dens_q;
  assign pitch_lo_o     = o_low_q;
  assign pitch_hi_o     = o_high_q;
  assign last_in_run_o  = o_last_q;

endmodule

// ===== design/note_phrase_segmenter.sv =====
// Top level of the note phrase segmenter: joins nps_ctrl and nps_dpath.
// Depends on nps_pkg, nps_ctrl and nps_dpath.
// Flow: a phrase closed by the next note goes through S_EVAL, the 16-step divider in S_DIV
// and the output register; one closed by the final flag through S_EVAL, S_FINAL, the divider
// and the output register. The input stays stalled until S_IDLE; output stalls hold S_DIV.
// Reset is asynchronous, active low: no phrase open, registers at their defaults.
module note_phrase_segmenter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nps_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [31:0]                  start_tick_i,
  input  logic [23:0]                  note_length_i,
  input  logic [6:0]                   pitch_i,
  input  logic                         is_final_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  seg_start_o,
  output logic [31:0]                  seg_end_o,
  output logic [15:0]                  density_q8_8_o,
  output logic [6:0]                   pitch_lo_o,
  output logic [6:0]                   pitch_hi_o,
  output logic                         last_in_run_o
);
  import nps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nps_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_tick_i   (start_tick_i),
    .note_length_i  (note_length_i),
    .pitch_i        (pitch_i),
    .is_final_i     (is_final_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .seg_start_o    (seg_start_o),
    .seg_end_o      (seg_end_o),
    .density_q8_8_o (density_q8_8_o),
    .pitch_lo_o     (pitch_lo_o),
    .pitch_hi_o     (pitch_hi_o),
    .last_in_run_o  (last_in_run_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// ===== design/nps_checker.sv =====
// Port-level checks for the note phrase segmenter, bound to the top level.
// Depends on note_phrase_segmenter.
module nps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] seg_start_o,
  input logic [31:0] seg_end_o,
  input logic [6:0]  pitch_lo_o,
  input logic [6:0]  pitch_hi_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transfer withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(seg_start_o) && $stable(seg_end_o))
    else $error("stalled phrase changed");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_pitch_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pitch_lo_o <= pitch_hi_o)
    else $error("lowest pitch above highest pitch");

  a_end_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seg_end_o >= seg_start_o)
    else $error("phrase ends before it starts");

endmodule

bind note_phrase_segmenter nps_checker u_nps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .seg_start_o (seg_start_o),
  .seg_end_o   (seg_end_o),
  .pitch_lo_o  (pitch_lo_o),
  .pitch_hi_o  (pitch_hi_o)
);

// ===== dv/tb_note_phrase_segmenter.sv =====
// Self-checking testbench for note_phrase_segmenter: a directed table, random note tracks and a
// full-length note stack, checked phrase by phrase against typed phrases or an in-file predictor.
// Depends on nps_pkg and the note_phrase_segmenter RTL.
module tb_note_phrase_segmenter;
  import nps_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned DrainCycles = 48;

  typedef struct packed {
    logic [31:0] st;
    logic [23:0] len;
    logic [6:0]  pitch;
    logic        fin;
  } note_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] stop;
    logic [15:0] dens;
    logic [6:0]  low;
    logic [6:0]  high;
    logic        last;
  } phrase_t;

  typedef struct packed {
    logic [15:0] gap;
    logic [15:0] minl;
    note_t       n;
    int          nexp;
    phrase_t     want;
  } step_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [31:0]         start_tick_i;
  logic [23:0]         note_length_i;
  logic [6:0]          pitch_i;
  logic                is_final_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [31:0]         seg_start_o;
  logic [31:0]         seg_end_o;
  logic [15:0]         density_q8_8_o;
  logic [6:0]          pitch_lo_o;
  logic [6:0]          pitch_hi_o;
  logic                last_in_run_o;

  logic        ph_open;
  logic [31:0] ph_start;
  logic [31:0] ph_stop;
  logic [31:0] ph_sum;
  logic [6:0]  ph_low;
  logic [6:0]  ph_high;
  logic [15:0] gap_thr;
  logic [15:0] min_len;

  phrase_t     phrases_made[$];
  phrase_t     phrases_due[$];
  step_t       steps [20];
  int unsigned mismatches = 0;
  int unsigned notes_sent = 0;
  int unsigned quiet_cycles = 0;
  logic        calm = 1'b0;

  note_phrase_segmenter dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] clamp32(longint t);
    if (t < 0) return 32'h0;
    return (t > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  function automatic logic [15:0] density(logic [31:0] sum, logic [31:0] span);
    logic [39:0] q;
    if (span == 32'h0) return (sum != 32'h0) ? 16'hFFFF : 16'h0;
    q = {sum, 8'h00} / {8'h00, span};
    return (q > 40'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic void report_open();
    logic [31:0] span;
    phrase_t     p;
    span = ph_stop - ph_start;
    if (span < {16'h0, min_len}) return;
    p = '{ph_start, ph_stop, density(ph_sum, span), ph_low, ph_high, 1'b0};
    phrases_made.insert(phrases_made.size(), p);
  endfunction

  function automatic void open_phrase(note_t n, logic [31:0] stop);
    ph_open  = 1'b1;
    ph_start = n.st;
    ph_stop  = stop;
    ph_low   = n.pitch;
    ph_high  = n.pitch;
    ph_sum   = {8'h0, n.len};
  endfunction

  // Folds one note into the phrase state and leaves the phrases it closes in phrases_made.
  function automatic void fold_note(note_t n);
    logic [31:0] stop;
    logic [31:0] gap;
    stop = add_sat(n.st, {8'h0, n.len});
    phrases_made.delete();
    if (!ph_open) begin
      open_phrase(n, stop);
    end else begin
      gap = (n.st > ph_stop) ? n.st - ph_stop : 32'h0;
      if (gap >= {16'h0, gap_thr}) begin
        report_open();
        open_phrase(n, stop);
      end else begin
        if (stop > ph_stop) ph_stop = stop;
        if (n.pitch < ph_low) ph_low = n.pitch;
        if (n.pitch > ph_high) ph_high = n.pitch;
        ph_sum = add_sat(ph_sum, {8'h0, n.len});
      end
    end
    if (n.fin) begin
      report_open();
      ph_open  = 1'b0;
      ph_start = '0;
      ph_stop  = '0;
      ph_low   = '0;
      ph_high  = '0;
      ph_sum   = '0;
    end
    if (phrases_made.size() != 0) phrases_made[phrases_made.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // A negative count takes the predicted phrases; otherwise the typed one is expected, or none.
  task automatic send_note(note_t n, int nexp = -1, phrase_t typed = '0);
    if (!calm && $urandom_range(0, 99) < 23) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    fold_note(n);
    if (nexp < 0) begin
      foreach (phrases_made[i]) phrases_due.insert(phrases_due.size(), phrases_made[i]);
    end else if (nexp > 0) begin
      phrases_due.insert(phrases_due.size(), typed);
    end
    in_valid_i    = 1'b1;
    start_tick_i  = n.st;
    note_length_i = n.len;
    pitch_i       = n.pitch;
    is_final_i    = n.fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    notes_sent++;
  endtask

  task automatic hold_for_results();
    in_valid_i = 1'b0;
    while (phrases_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_config(logic [15:0] gap, logic [15:0] minl);
    hold_for_results();
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = CFG_GAP_THR;
    cfg_data_i = gap;
    @(negedge clk_i);
    cfg_idx_i  = CFG_MIN_LEN;
    cfg_data_i = minl;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    gap_thr    = gap;
    min_len    = minl;
  endtask

  // One track: notes that mostly join, some that land around the gap threshold, a few
  // out of order or fully random, ending on a final note.
  task automatic play_track(int unsigned count);
    note_t       n;
    logic [31:0] prev;
    logic [31:0] anchor;
    int unsigned pick;
    int unsigned lsel;
    int unsigned d;
    pick = $urandom_range(0, 99);
    if (pick < 15) prev = $urandom;
    else if (pick < 25) prev = 32'hFFFF_FFFF - $urandom_range(0, 1 << 18);
    else prev = $urandom_range(0, 1 << 24);
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        n.st = $urandom;
      end else if (pick < 14) begin
        d = $urandom_range(0, 200);
        n.st = (prev > d) ? prev - d : 32'h0;
      end else if (pick < 50) begin
        n.st = clamp32(longint'(prev) + longint'($urandom_range(0, gap_thr)));
      end else begin
        anchor = ph_open ? ph_stop : prev;
        if ($urandom_range(0, 1) == 1)
          n.st = clamp32(longint'(anchor) + longint'(gap_thr) + longint'($urandom_range(0, 6)) - 3);
        else
          n.st = clamp32(longint'(anchor) + longint'($urandom_range(0, 2 * gap_thr + 2)));
      end
      lsel = $urandom_range(0, 99);
      if (lsel < 10) n.len = '0;
      else if (lsel < 22) n.len = 24'($urandom);
      else n.len = 24'($urandom_range(0, min_len + min_len / 2 + 8));
      n.pitch = 7'($urandom_range(0, 127));
      n.fin   = (k == count - 1) || ($urandom_range(0, 99) < 4);
      prev    = n.st;
      send_note(n);
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 23);
  end

  always @(posedge clk_i) begin : check_out
    phrase_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (phrases_due.size() == 0) begin
        mismatches++;
        $display("%0t: phrase %h..%h arrived with none expected", $time, seg_start_o,
                 seg_end_o);
      end else begin
        want = phrases_due.pop_front();
        check_field("seg_start", want.start, seg_start_o);
        check_field("seg_end", want.stop, seg_end_o);
        check_field("density_q8_8", 32'(want.dens), 32'(density_q8_8_o));
        check_field("pitch_lo", 32'(want.low), 32'(pitch_lo_o));
        check_field("pitch_hi", 32'(want.high), 32'(pitch_hi_o));
        check_field("last_in_run", 32'(want.last), 32'(last_in_run_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_note_phrase_segmenter: done, errors");
      $finish;
    end
  end

  initial begin
    note_t       n;
    logic [15:0] pg [5];
    logic [15:0] pm [5];
    int unsigned base;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_GAP_THR;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    start_tick_i  = '0;
    note_length_i = '0;
    pitch_i       = '0;
    is_final_i    = 1'b0;
    ph_open  = 1'b0;
    ph_start = '0;
    ph_stop  = '0;
    ph_sum   = '0;
    ph_low   = '0;
    ph_high  = '0;
    gap_thr  = GapThrReset;
    min_len  = MinLenReset;

    steps = '{
      '{16'd960, 16'd1920, '{32'd100, 24'd2000, 7'd60, 1'b0}, 0, '0},
      '{16'd960, 16'd1920, '{32'd500, 24'd100, 7'd127, 1'b0}, 0, '0},
      '{16'd960, 16'd1920, '{32'd3060, 24'd10, 7'd0, 1'b0}, 1,
        '{32'd100, 32'd2100, 16'd268, 7'd60, 7'd127, 1'b1}},
      '{16'd960, 16'd1920, '{32'd4029, 24'd0, 7'd0, 1'b0}, -1, '0},
      '{16'd960, 16'd1920, '{32'd4000, 24'hFF_FFFF, 7'd127, 1'b1}, -1, '0},
      '{16'd960, 16'd1920, '{32'hFFFF_FFFF, 24'hFF_FFFF, 7'd127, 1'b1}, 0, '0},
      '{16'd960, 16'd1920, '{32'd0, 24'd2000, 7'd10, 1'b0}, 0, '0},
      '{16'd960, 16'd1920, '{32'd5000, 24'd0, 7'd20, 1'b1}, 1,
        '{32'd0, 32'd2000, 16'd256, 7'd10, 7'd10, 1'b1}},
      '{16'd960, 16'd1920, '{32'd10000, 24'd1920, 7'd5, 1'b0}, 0, '0},
      '{16'd960, 16'd1920, '{32'd20000, 24'd1920, 7'd6, 1'b1}, -1, '0},
      '{16'd0, 16'd0, '{32'd100, 24'd0, 7'd1, 1'b0}, 0, '0},
      '{16'd0, 16'd0, '{32'd100, 24'd0, 7'd2, 1'b0}, 1,
        '{32'd100, 32'd100, 16'd0, 7'd1, 7'd1, 1'b1}},
      '{16'd0, 16'd0, '{32'd100, 24'd0, 7'd3, 1'b1}, -1, '0},
      '{16'd0, 16'd0, '{32'hFFFF_FFFF, 24'd5, 7'd127, 1'b1}, 1,
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 7'd127, 7'd127, 1'b1}},
      '{16'hFFFF, 16'd0, '{32'h0100_0000, 24'd1, 7'd50, 1'b0}, 0, '0},
      '{16'hFFFF, 16'd0, '{32'd0, 24'hFF_FFFF, 7'd51, 1'b1}, 1,
        '{32'h0100_0000, 32'h0100_0001, 16'hFFFF, 7'd50, 7'd51, 1'b1}},
      '{16'hFFFF, 16'hFFFF, '{32'd0, 24'd65535, 7'd0, 1'b0}, 0, '0},
      '{16'hFFFF, 16'hFFFF, '{32'd131070, 24'd0, 7'd127, 1'b0}, 1,
        '{32'd0, 32'd65535, 16'd256, 7'd0, 7'd0, 1'b1}},
      '{16'hFFFF, 16'hFFFF, '{32'd196604, 24'hFF_FFFF, 7'd64, 1'b1}, -1, '0},
      '{16'hFFFF, 16'hFFFF, '{32'd0, 24'd65534, 7'd9, 1'b1}, 0, '0}
    };

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < 20; i++) begin
      if (steps[i].gap != gap_thr || steps[i].minl != min_len)
        set_config(steps[i].gap, steps[i].minl);
      send_note(steps[i].n, steps[i].nexp, steps[i].want);
    end

    pg = '{16'd1, 16'd960, 16'hFFFF, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 64))};
    pm = '{16'd0, 16'd1920, 16'hFFFF, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 256))};
    for (int p = 0; p < 5; p++) begin
      set_config(pg[p], pm[p]);
      calm = (p == 1);
      base = notes_sent;
      while (notes_sent - base < 135) begin
        play_track($urandom_range(1, 12));
        if ($urandom_range(0, 99) < 3) hold_for_results();
      end
    end

    // Enough full-length notes stacked on one start to drive the duration sum into saturation.
    n.st = $urandom_range(0, 1 << 30);
    for (int k = 0; k < 260; k++) begin
      n.len   = 24'hFF_FFFF;
      n.pitch = 7'($urandom_range(0, 127));
      n.fin   = (k == 259);
      send_note(n);
    end

    hold_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && phrases_due.size() == 0) begin
      $display("tb_note_phrase_segmenter: done, clean");
    end else begin
      $display("tb_note_phrase_segmenter: done, errors");
    end
    $finish;
  end

endmodule
